>>> rtl/i2cms_pkg.sv
// Shared types, codes and helpers for the I2C master bit sequencer.
`default_nettype none

package i2cms_pkg;

  // Register indexes on the configuration port (selected by paddr[2])
  localparam logic REG_TICKS_PER_US = 1'b0;
  localparam logic REG_ACK_POLL_LIM = 1'b1;

  localparam logic [9:0] TICKS_PER_US_RESET = 10'd72;
  localparam logic [7:0] ACK_POLL_LIM_RESET = 8'd250;
  localparam logic [7:0] POLL_COUNT_MAX     = 8'd255;

  // Command codes carried by a tick
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_WAIT  = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  // Sequencer steps
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_ST_C    = 5'd3,
    PH_ST_D    = 5'd4,
    PH_SP_A    = 5'd5,
    PH_SP_B    = 5'd6,
    PH_SP_C    = 5'd7,
    PH_WA_A    = 5'd8,
    PH_WA_B    = 5'd9,
    PH_WA_P    = 5'd10,
    PH_WR_BIT  = 5'd11,
    PH_WR_HI   = 5'd12,
    PH_WR_LO   = 5'd13,
    PH_WR_END  = 5'd14,
    PH_RD_LO   = 5'd15,
    PH_RD_HI   = 5'd16,
    PH_RD_HOLD = 5'd17,
    PH_MA_A    = 5'd18,
    PH_MA_B    = 5'd19,
    PH_MA_C    = 5'd20
  } phase_t;

  // Hold length of a step in microsecond units
  typedef enum logic [1:0] {
    UNITS_1 = 2'd0,
    UNITS_2 = 2'd1,
    UNITS_4 = 2'd2,
    UNITS_5 = 2'd3
  } units_t;

  // One result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       command_done;
    logic [7:0] received_byte;
    logic       ack_timeout;
  } status_t;

  // Hold counter load: units * ticks - 1, a zero tick count acts as one
  function automatic logic [12:0] hold_load(input logic [9:0] ticks, input units_t units);
    logic [9:0]  t_eff;
    logic [12:0] x1;
    logic [12:0] x4;
    logic [12:0] prod;
    t_eff = (ticks == 10'd0) ? 10'd1 : ticks;
    x1    = {3'b000, t_eff};
    x4    = {1'b0, t_eff, 2'b00};
    unique case (units)
      UNITS_1: prod = x1;
      UNITS_2: prod = {2'b00, t_eff, 1'b0};
      UNITS_4: prod = x4;
      UNITS_5: prod = x4 + x1;
      default: prod = x1;
    endcase
    return prod - 13'd1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/i2cms_if.sv
// Valid/ready channel interfaces for ticks in and status beats out.
`default_nettype none

interface i2cms_tick_if;
  logic       valid;
  logic       ready;
  logic       command_valid;
  logic [2:0] operation;
  logic [7:0] transmit_byte;
  logic       master_acknowledge;
  logic       sda_sample;

  modport source (output valid, command_valid, operation, transmit_byte,
                  master_acknowledge, sda_sample, input ready);
  modport sink   (input valid, command_valid, operation, transmit_byte,
                  master_acknowledge, sda_sample, output ready);
endinterface

interface i2cms_status_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive_enable;
  logic       busy_res;
  logic       command_done;
  logic [7:0] received_byte;
  logic       ack_timeout;

  modport source (output valid, scl_level, sda_level, sda_drive_enable, busy_res,
                  command_done, received_byte, ack_timeout, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive_enable, busy_res,
                  command_done, received_byte, ack_timeout, output ready);
endinterface

`default_nettype wire

>>> rtl/i2c_master_bit_sequencer_core.sv
// I2C master bit sequencer: steps SCL/SDA through start, stop, write, ack wait and read.
//
// Usage:
//   tick   : one beat per bus clock tick. It carries an optional command
//            (start, stop, write byte, wait ack, read byte) and the sampled
//            SDA pin. Commands are taken only while the sequencer is idle.
//   status : one beat per tick beat, with the pin drive after that tick,
//            busy, a one-beat done pulse, the last received byte and the
//            ack-timeout flag.
//   APB    : ticks_per_microsecond at 0x0, ack_poll_limit at 0x4; write
//            only while no beat is in flight.
// Each status beat is registered in the status register (or the skid register).
// Throughput is one tick beat per cycle while tick.ready is high; the next-state
// logic is a single pass between the sequencer registers and the status register.
// A skid register behind the status register holds one more beat while the
// receiver stalls; tick.ready drops only once that skid register is full.
// Reset (rst, synchronous) sets the sequencer idle with SCL and SDA high and
// driven, and reloads both configuration registers with their defaults.
`default_nettype none

module i2c_master_bit_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  i2cms_tick_if.sink       tick,
  i2cms_status_if.source   status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Configuration registers
  logic [9:0] ticks_per_us;
  logic [7:0] ack_poll_limit;

  // Sequencer state
  i2cms_pkg::phase_t phase, phase_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [12:0] delay_count, delay_count_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [7:0]  rx_latch, rx_latch_next;
  logic        timeout_flag, timeout_flag_next;
  logic        ack_choice, ack_choice_next;
  logic        pin_scl, pin_scl_next;
  logic        pin_sda, pin_sda_next;
  logic        pin_oe, pin_oe_next;

  // Step entry request
  logic                enter_en;
  i2cms_pkg::phase_t   enter_ph;
  i2cms_pkg::units_t   enter_units;
  logic                scl_drop;
  logic                done;
  logic [7:0]          poll_inc;

  // Output register and skid register
  i2cms_pkg::status_t out_reg, skid_reg, beat_next;
  logic               out_valid, skid_valid;
  logic               in_fire, out_fire;

  // APB port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us   <= i2cms_pkg::TICKS_PER_US_RESET;
      ack_poll_limit <= i2cms_pkg::ACK_POLL_LIM_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        i2cms_pkg::REG_TICKS_PER_US: ticks_per_us   <= pwdata[9:0];
        i2cms_pkg::REG_ACK_POLL_LIM: ack_poll_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      i2cms_pkg::REG_TICKS_PER_US: prdata = {22'd0, ticks_per_us};
      i2cms_pkg::REG_ACK_POLL_LIM: prdata = {24'd0, ack_poll_limit};
      default:                     prdata = 32'd0;
    endcase
  end

  // Handshakes
  assign tick.ready = !skid_valid;
  assign in_fire    = tick.valid && tick.ready;
  assign out_fire   = out_valid && status.ready;

  assign poll_inc = (poll_count < i2cms_pkg::POLL_COUNT_MAX) ? poll_count + 8'd1 : poll_count;

  // Next state: step sequencing, counters and data registers
  always_comb begin
    phase_next        = phase;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    poll_count_next   = poll_count;
    rx_latch_next     = rx_latch;
    timeout_flag_next = timeout_flag;
    ack_choice_next   = ack_choice;
    delay_count_next  = delay_count;
    enter_en          = 1'b0;
    enter_ph          = i2cms_pkg::PH_IDLE;
    enter_units       = i2cms_pkg::UNITS_2;
    scl_drop          = 1'b0;
    done              = 1'b0;

    if (phase == i2cms_pkg::PH_IDLE) begin
      // New command, ignored unless the code is known
      if (tick.command_valid) begin
        unique case (tick.operation)
          i2cms_pkg::OP_START: begin
            enter_en = 1'b1; enter_ph = i2cms_pkg::PH_ST_A;
          end
          i2cms_pkg::OP_STOP: begin
            enter_en = 1'b1; enter_ph = i2cms_pkg::PH_SP_A;
          end
          i2cms_pkg::OP_WRITE: begin
            shift_byte_next = tick.transmit_byte;
            bit_index_next  = 4'd0;
            enter_en = 1'b1; enter_ph = i2cms_pkg::PH_WR_BIT;
          end
          i2cms_pkg::OP_WAIT: begin
            poll_count_next = 8'd0;
            enter_en = 1'b1; enter_ph = i2cms_pkg::PH_WA_A;
          end
          i2cms_pkg::OP_READ: begin
            shift_byte_next = 8'd0;
            bit_index_next  = 4'd0;
            ack_choice_next = tick.master_acknowledge;
            enter_en = 1'b1; enter_ph = i2cms_pkg::PH_RD_LO;
            enter_units = i2cms_pkg::UNITS_5;
          end
          default: ;
        endcase
      end
    end else if (delay_count != 13'd0) begin
      delay_count_next = delay_count - 13'd1;
    end else begin
      // Hold expired: leave the current step
      unique case (phase)
        i2cms_pkg::PH_ST_A: begin
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_ST_B; enter_units = i2cms_pkg::UNITS_5;
        end
        i2cms_pkg::PH_ST_B: begin
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_ST_C; enter_units = i2cms_pkg::UNITS_4;
        end
        i2cms_pkg::PH_ST_C: begin
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_ST_D;
        end
        i2cms_pkg::PH_SP_A: begin
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_SP_B; enter_units = i2cms_pkg::UNITS_5;
        end
        i2cms_pkg::PH_SP_B: begin
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_SP_C; enter_units = i2cms_pkg::UNITS_4;
        end
        i2cms_pkg::PH_WA_A: begin
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_WA_B;
        end
        i2cms_pkg::PH_WA_B, i2cms_pkg::PH_WA_P: begin
          // Ack poll: low SDA ends the wait, else count toward timeout
          if (!tick.sda_sample) begin
            scl_drop          = 1'b1;
            timeout_flag_next = 1'b0;
            phase_next        = i2cms_pkg::PH_IDLE;
            done              = 1'b1;
          end else begin
            poll_count_next = poll_inc;
            enter_en        = 1'b1;
            if (poll_inc >= ack_poll_limit) begin
              timeout_flag_next = 1'b1;
              enter_ph          = i2cms_pkg::PH_SP_A;
            end else begin
              enter_ph    = i2cms_pkg::PH_WA_P;
              enter_units = i2cms_pkg::UNITS_1;
            end
          end
        end
        i2cms_pkg::PH_WR_BIT: begin
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_WR_HI; enter_units = i2cms_pkg::UNITS_4;
        end
        i2cms_pkg::PH_WR_HI: begin
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_WR_LO;
        end
        i2cms_pkg::PH_WR_LO: begin
          bit_index_next = bit_index + 4'd1;
          enter_en = 1'b1;
          enter_ph = (bit_index_next < 4'd8) ? i2cms_pkg::PH_WR_BIT : i2cms_pkg::PH_WR_END;
        end
        i2cms_pkg::PH_RD_LO: begin
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_RD_HI;
        end
        i2cms_pkg::PH_RD_HI: begin
          shift_byte_next = {shift_byte[6:0], tick.sda_sample};
          bit_index_next  = bit_index + 4'd1;
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_RD_HOLD;
        end
        i2cms_pkg::PH_RD_HOLD: begin
          enter_en = 1'b1;
          if (bit_index < 4'd8) begin
            enter_ph = i2cms_pkg::PH_RD_LO; enter_units = i2cms_pkg::UNITS_5;
          end else begin
            rx_latch_next = shift_byte;
            enter_ph = i2cms_pkg::PH_MA_A;
          end
        end
        i2cms_pkg::PH_MA_A: begin
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_MA_B; enter_units = i2cms_pkg::UNITS_4;
        end
        i2cms_pkg::PH_MA_B: begin
          enter_en = 1'b1; enter_ph = i2cms_pkg::PH_MA_C;
        end
        default: begin
          // Last step of a command
          phase_next = i2cms_pkg::PH_IDLE;
          done       = 1'b1;
        end
      endcase
    end

    if (enter_en) begin
      phase_next       = enter_ph;
      delay_count_next = i2cms_pkg::hold_load(ticks_per_us, enter_units);
    end
  end

  // Pin drive set on entry to a step
  always_comb begin
    pin_scl_next = scl_drop ? 1'b0 : pin_scl;
    pin_sda_next = pin_sda;
    pin_oe_next  = pin_oe;
    if (enter_en) begin
      unique case (enter_ph)
        i2cms_pkg::PH_ST_A:   begin pin_oe_next = 1'b1; pin_sda_next = 1'b1; end
        i2cms_pkg::PH_ST_B:   pin_scl_next = 1'b1;
        i2cms_pkg::PH_ST_C:   pin_sda_next = 1'b0;
        i2cms_pkg::PH_ST_D:   pin_scl_next = 1'b0;
        i2cms_pkg::PH_SP_A:   begin pin_oe_next = 1'b1; pin_sda_next = 1'b0; end
        i2cms_pkg::PH_SP_B:   pin_scl_next = 1'b1;
        i2cms_pkg::PH_SP_C:   pin_sda_next = 1'b1;
        i2cms_pkg::PH_WA_A:   begin pin_oe_next = 1'b0; pin_sda_next = 1'b1; end
        i2cms_pkg::PH_WA_B:   pin_scl_next = 1'b1;
        i2cms_pkg::PH_WR_BIT: begin
          pin_oe_next  = 1'b1;
          pin_sda_next = shift_byte_next[3'd7 - bit_index_next[2:0]];
        end
        i2cms_pkg::PH_WR_HI:  pin_scl_next = 1'b1;
        i2cms_pkg::PH_WR_LO:  pin_scl_next = 1'b0;
        i2cms_pkg::PH_WR_END: pin_scl_next = 1'b0;
        i2cms_pkg::PH_RD_LO:  begin pin_oe_next = 1'b0; pin_scl_next = 1'b0; end
        i2cms_pkg::PH_RD_HI:  pin_scl_next = 1'b1;
        i2cms_pkg::PH_MA_A:   begin
          pin_scl_next = 1'b0;
          pin_oe_next  = 1'b1;
          pin_sda_next = !ack_choice;
        end
        i2cms_pkg::PH_MA_B:   pin_scl_next = 1'b1;
        i2cms_pkg::PH_MA_C:   pin_scl_next = 1'b0;
        default: ;
      endcase
    end
  end

  // Status beat for this tick
  always_comb begin
    beat_next.scl_level        = pin_scl_next;
    beat_next.sda_level        = pin_sda_next;
    beat_next.sda_drive_enable = pin_oe_next;
    beat_next.busy_res         = (phase_next != i2cms_pkg::PH_IDLE);
    beat_next.command_done     = done;
    beat_next.received_byte    = rx_latch_next;
    beat_next.ack_timeout      = timeout_flag_next;
  end

  // Sequencer registers advance once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= i2cms_pkg::PH_IDLE;
      bit_index    <= 4'd0;
      shift_byte   <= 8'd0;
      delay_count  <= 13'd0;
      poll_count   <= 8'd0;
      rx_latch     <= 8'd0;
      timeout_flag <= 1'b0;
      ack_choice   <= 1'b0;
      pin_scl      <= 1'b1;
      pin_sda      <= 1'b1;
      pin_oe       <= 1'b1;
    end else if (in_fire) begin
      phase        <= phase_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      delay_count  <= delay_count_next;
      poll_count   <= poll_count_next;
      rx_latch     <= rx_latch_next;
      timeout_flag <= timeout_flag_next;
      ack_choice   <= ack_choice_next;
      pin_scl      <= pin_scl_next;
      pin_sda      <= pin_sda_next;
      pin_oe       <= pin_oe_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_reg <= skid_reg;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_reg <= beat_next;
      end else begin
        skid_reg <= beat_next;
      end
    end
  end

  assign status.valid            = out_valid;
  assign status.scl_level        = out_reg.scl_level;
  assign status.sda_level        = out_reg.sda_level;
  assign status.sda_drive_enable = out_reg.sda_drive_enable;
  assign status.busy_res         = out_reg.busy_res;
  assign status.command_done     = out_reg.command_done;
  assign status.received_byte    = out_reg.received_byte;
  assign status.ack_timeout      = out_reg.ack_timeout;

endmodule

`default_nettype wire
